FILE: rtl/core/mtm_pkg.sv
// ----------------------------------------------------------------------------
// mtm_pkg: shared types and constants for the MUS to MIDI event transcoder
// Result kinds, parser phases, the job handed from front to back, the result
// beat, and the MUS controller lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtm_pkg;

  localparam int NUM_TRACKS = 16;
  localparam int JOB_DEPTH  = 2;
  localparam int OUT_DEPTH  = 2;

  localparam logic [4:0] UNMAPPED  = 5'h10;
  localparam logic [4:0] PERC_MIDI = 5'd9;
  localparam logic [4:0] MIDI_LAST = 5'd15;
  localparam logic [4:0] SKIP_FROM = 5'd8;
  localparam logic [4:0] SKIP_TO   = 5'd10;
  localparam logic [3:0] PERC_MUS  = 4'd15;

  localparam logic [7:0] ST_NOTE = 8'h90;
  localparam logic [7:0] ST_BEND = 8'hE0;
  localparam logic [7:0] ST_CTRL = 8'hB0;
  localparam logic [7:0] ST_PROG = 8'hC0;
  localparam logic [7:0] DEF_VEL = 8'd64;
  localparam logic [7:0] CTL_MAX  = 8'd14;
  localparam logic [7:0] CTL_MONO = 8'd12;

  // MUS event types
  localparam logic [2:0] ET_OFF  = 3'd0;
  localparam logic [2:0] ET_ON   = 3'd1;
  localparam logic [2:0] ET_BEND = 3'd2;
  localparam logic [2:0] ET_CTRL = 3'd3;
  localparam logic [2:0] ET_CHG  = 3'd4;
  localparam logic [2:0] ET_BAD5 = 3'd5;
  localparam logic [2:0] ET_END  = 3'd6;
  localparam logic [2:0] ET_BAD7 = 3'd7;

  // configuration register indexes
  localparam logic REG_MELODIC = 1'b0;
  localparam logic REG_RUNSTAT = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_END      = 2'd1,
    KIND_CORRUPT  = 2'd2,
    KIND_CHANNELS = 2'd3
  } kind_t;

  typedef enum logic [7:0] {
    PH_EVENT  = 8'b0000_0001,
    PH_OFF    = 8'b0000_0010,
    PH_ON     = 8'b0000_0100,
    PH_BEND   = 8'b0000_1000,
    PH_CTRL   = 8'b0001_0000,
    PH_CHGSEL = 8'b0010_0000,
    PH_VALUE  = 8'b0100_0000,
    PH_TIME   = 8'b1000_0000
  } phase_t;

  // one job: optional varlen delta, then up to two literal bytes, or a halt
  typedef struct packed {
    logic [3:0]  track;
    kind_t       kind;
    logic [2:0]  dcnt;
    logic [31:0] delta;
    logic [1:0]  nb;
    logic [7:0]  b0;
    logic [7:0]  b1;
  } job_t;

  typedef struct packed {
    logic [3:0] track;
    logic [7:0] midi_byte;
    kind_t      kind;
    logic       last;
  } result_t;

  function automatic logic [7:0] ctl_map(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0, 4'd1: r = 8'h00;
      4'd2:       r = 8'h01;
      4'd3:       r = 8'h07;
      4'd4:       r = 8'h0A;
      4'd5:       r = 8'h0B;
      4'd6:       r = 8'h5B;
      4'd7:       r = 8'h5D;
      4'd8:       r = 8'h40;
      4'd9:       r = 8'h43;
      4'd10:      r = 8'h78;
      4'd11:      r = 8'h7B;
      4'd12:      r = 8'h7E;
      4'd13:      r = 8'h7F;
      4'd14:      r = 8'h79;
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

  // number of 7-bit groups in a MIDI variable-length quantity
  function automatic logic [2:0] varlen_len(input logic [31:0] v);
    logic [2:0] k;
    if (v[31:28] != '0)      k = 3'd5;
    else if (v[27:21] != '0) k = 3'd4;
    else if (v[20:14] != '0) k = 3'd3;
    else if (v[13:7] != '0)  k = 3'd2;
    else                     k = 3'd1;
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mtm_fifo.sv
// ----------------------------------------------------------------------------
// mtm_fifo: small synchronous queue
// Register-array FIFO with full/empty flags, used between the stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtm_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  item_t      wr_data,
  output logic       full,
  input  wire logic  rd_en,
  output item_t      rd_data,
  output logic       empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      if (do_rd) rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      if (do_wr && !do_rd)      count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_data;
  end

endmodule

`default_nettype wire

FILE: rtl/core/mtm_front.sv
// ----------------------------------------------------------------------------
// mtm_front: score parser
// Takes one score byte per beat, tracks channel binding and per-track state,
// and turns each byte into at most one job for the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtm_front (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  output logic        full,
  input  wire logic [7:0] score_byte,
  input  wire logic   new_song,
  input  wire logic   cfg_we,
  input  wire logic   cfg_index,
  input  wire logic [3:0] cfg_data,
  output logic        job_push,
  output mtm_pkg::job_t job,
  input  wire logic   job_full
);
  import mtm_pkg::*;

  logic [3:0]  melodic;
  logic        rse;

  phase_t      phase, phase_next;
  logic [7:0]  cur_event, cur_event_next;
  logic [3:0]  cur_track, cur_track_next;
  logic [4:0]  chan_map [16];
  logic [3:0]  trk_of_ch [16];
  logic [4:0]  tiu;
  logic [4:0]  next_free, next_free_next;
  logic [7:0]  run_stat [NUM_TRACKS];
  logic [7:0]  velocity [NUM_TRACKS];
  logic [31:0] base [NUM_TRACKS];   // time total when track last wrote its delta
  logic [31:0] total;               // running time sum since song start
  logic [31:0] tgather, tgather_next, total_next;
  logic        stopped, stopped_next;

  logic        accept;
  logic        e_stopped;
  phase_t      e_phase;
  logic [4:0]  e_tiu, e_next_free;
  logic [31:0] e_total;
  logic [2:0]  et;
  logic [3:0]  ch;
  logic        mapped, bind_bad;
  logic [4:0]  bind_c;
  logic [3:0]  mc, t, cur_mc, ct;
  logic [31:0] delta;
  logic        do_bind, wr_rs, wr_vel, wr_base;
  logic [7:0]  rs_val;
  logic [3:0]  rs_idx;
  logic [7:0]  st;
  logic        st_emit;

  assign accept = push && !job_full;
  assign full   = job_full;

  assign e_stopped   = new_song ? 1'b0 : stopped;
  assign e_phase     = new_song ? PH_EVENT : phase;
  assign e_tiu       = new_song ? '0 : tiu;
  assign e_next_free = new_song ? '0 : next_free;
  assign e_total     = new_song ? '0 : total;

  assign et       = score_byte[6:4];
  assign ch       = score_byte[3:0];
  assign mapped   = !new_song && (chan_map[ch] != UNMAPPED);
  assign bind_c   = (ch == PERC_MUS) ? PERC_MIDI : e_next_free;
  assign bind_bad = (bind_c > MIDI_LAST) || e_tiu[4];
  assign mc       = mapped ? chan_map[ch][3:0] : bind_c[3:0];
  assign t        = mapped ? trk_of_ch[mc] : e_tiu[3:0];
  assign delta    = mapped ? (e_total - base[t]) : '0;
  assign ct       = cur_track;
  assign cur_mc   = chan_map[cur_event[3:0]][3:0];
  assign rs_idx   = (e_phase == PH_EVENT) ? t : ct;

  // highest melodic binding plus one, hopping over the percussion channel
  assign next_free_next = (do_bind && ch != PERC_MUS) ?
                          ((bind_c == SKIP_FROM) ? SKIP_TO : bind_c + 5'd1) : e_next_free;

  always_comb begin
    phase_next     = phase;
    cur_event_next = cur_event;
    cur_track_next = cur_track;
    tgather_next   = tgather;
    total_next     = e_total;
    stopped_next   = e_stopped;
    do_bind        = 1'b0;
    wr_rs          = 1'b0;
    wr_vel         = 1'b0;
    wr_base        = 1'b0;
    rs_val         = '0;
    st             = '0;
    st_emit        = 1'b0;
    job_push       = 1'b0;
    job            = '0;
    job.kind       = KIND_DATA;
    job.track      = ct;
    if (new_song) begin
      phase_next     = PH_EVENT;
      cur_event_next = '0;
      cur_track_next = '0;
      tgather_next   = '0;
    end
    if (accept && !e_stopped) begin
      unique case (e_phase)
        PH_EVENT: begin
          job_push = 1'b1;
          if (et == ET_END) begin
            job.kind     = KIND_END;
            job.track    = '0;
            stopped_next = 1'b1;
          end else if (!mapped && bind_bad) begin
            job.kind     = KIND_CHANNELS;
            job.track    = '0;
            stopped_next = 1'b1;
          end else begin
            do_bind        = !mapped;
            cur_track_next = t;
            cur_event_next = score_byte;
            if (et == ET_BAD5 || et == ET_BAD7) begin
              job.kind     = KIND_CORRUPT;
              job.track    = '0;
              stopped_next = 1'b1;
            end else begin
              wr_base    = 1'b1;
              job.track  = t;
              job.delta  = delta;
              job.dcnt   = varlen_len(delta);
              unique case (et)
                ET_OFF:  begin st = ST_NOTE | {4'h0, mc}; phase_next = PH_OFF;  end
                ET_ON:   begin st = ST_NOTE | {4'h0, mc}; phase_next = PH_ON;   end
                ET_BEND: begin st = ST_BEND | {4'h0, mc}; phase_next = PH_BEND; end
                ET_CTRL: begin st = ST_CTRL | {4'h0, mc}; phase_next = PH_CTRL; end
                default: phase_next = PH_CHGSEL;
              endcase
              if (et != ET_CHG) begin
                st_emit = !rse || !mapped || (run_stat[t] != st);
                wr_rs   = 1'b1;
                rs_val  = st;
                job.b0  = st;
                job.nb  = st_emit ? 2'd1 : 2'd0;
              end
            end
          end
        end
        PH_OFF: begin
          job_push   = 1'b1;
          job.nb     = 2'd2;
          job.b0     = score_byte;
          job.b1     = '0;
          phase_next = cur_event[7] ? PH_TIME : PH_EVENT;
          tgather_next = '0;
        end
        PH_ON: begin
          job_push = 1'b1;
          job.b0   = {1'b0, score_byte[6:0]};
          if (score_byte[7]) begin
            job.nb     = 2'd1;
            phase_next = PH_VALUE;
          end else begin
            job.nb       = 2'd2;
            job.b1       = velocity[ct];
            phase_next   = cur_event[7] ? PH_TIME : PH_EVENT;
            tgather_next = '0;
          end
        end
        PH_BEND: begin
          job_push     = 1'b1;
          job.nb       = 2'd2;
          job.b0       = {1'b0, score_byte[0], 6'b0};
          job.b1       = {1'b0, score_byte[7:1]};
          phase_next   = cur_event[7] ? PH_TIME : PH_EVENT;
          tgather_next = '0;
        end
        PH_CTRL: begin
          job_push = 1'b1;
          if (score_byte > CTL_MAX) begin
            job.kind     = KIND_CORRUPT;
            job.track    = '0;
            stopped_next = 1'b1;
          end else begin
            job.nb       = 2'd2;
            job.b0       = ctl_map(score_byte[3:0]);
            job.b1       = (score_byte == CTL_MONO) ? ({4'h0, melodic} + 8'd1) : 8'd0;
            phase_next   = cur_event[7] ? PH_TIME : PH_EVENT;
            tgather_next = '0;
          end
        end
        PH_CHGSEL: begin
          job_push = 1'b1;
          if (score_byte > CTL_MAX) begin
            job.kind     = KIND_CORRUPT;
            job.track    = '0;
            stopped_next = 1'b1;
          end else begin
            st      = (score_byte != '0) ? (ST_CTRL | {4'h0, cur_mc})
                                         : (ST_PROG | {4'h0, cur_mc});
            st_emit = !rse || (run_stat[ct] != st);
            wr_rs   = 1'b1;
            rs_val  = st;
            if (score_byte != '0) begin
              job.b0 = st_emit ? st : ctl_map(score_byte[3:0]);
              job.b1 = ctl_map(score_byte[3:0]);
              job.nb = st_emit ? 2'd2 : 2'd1;
            end else begin
              job.b0 = st;
              job.nb = st_emit ? 2'd1 : 2'd0;
            end
            job_push   = st_emit || (score_byte != '0);
            phase_next = PH_VALUE;
          end
        end
        PH_VALUE: begin
          job_push     = 1'b1;
          job.nb       = 2'd1;
          job.b0       = score_byte;
          wr_vel       = (cur_event[6:4] == ET_ON);
          phase_next   = cur_event[7] ? PH_TIME : PH_EVENT;
          tgather_next = '0;
        end
        PH_TIME: begin
          tgather_next = {tgather[24:0], 7'b0} + {25'b0, score_byte[6:0]};
          if (!score_byte[7]) begin
            total_next = e_total + tgather_next;
            phase_next = PH_EVENT;
          end
        end
        default: phase_next = PH_EVENT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      melodic <= '0;
      rse     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MELODIC: melodic <= cfg_data;
        REG_RUNSTAT: rse     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_EVENT;
      cur_event <= '0;
      cur_track <= '0;
      tiu       <= '0;
      next_free <= '0;
      total     <= '0;
      tgather   <= '0;
      stopped   <= 1'b0;
      for (int i = 0; i < 16; i++) chan_map[i] <= UNMAPPED;
      for (int i = 0; i < NUM_TRACKS; i++) begin
        run_stat[i] <= '0;
        velocity[i] <= DEF_VEL;
      end
    end else if (accept) begin
      // new song clears per-channel and per-track state; this byte's own
      // binding or status write wins over the clear
      for (int i = 0; i < 16; i++) begin
        chan_map[i] <= (do_bind && ch == 4'(i)) ? bind_c
                     : (new_song ? UNMAPPED : chan_map[i]);
      end
      for (int i = 0; i < NUM_TRACKS; i++) begin
        run_stat[i] <= (wr_rs && rs_idx == 4'(i)) ? rs_val
                     : (new_song ? 8'd0 : run_stat[i]);
        velocity[i] <= (wr_vel && ct == 4'(i)) ? score_byte
                     : (new_song ? DEF_VEL : velocity[i]);
      end
      phase     <= phase_next;
      cur_event <= cur_event_next;
      cur_track <= cur_track_next;
      total     <= total_next;
      tgather   <= tgather_next;
      stopped   <= stopped_next;
      tiu       <= e_tiu + {4'b0, do_bind};
      next_free <= next_free_next;
    end
  end

  // payload stores, no reset
  always_ff @(posedge clk) begin
    if (accept && !e_stopped && do_bind) trk_of_ch[mc] <= t;
    if (accept && !e_stopped && (wr_base || do_bind)) base[t] <= e_total;
  end

  a_halt_stops: assert property (@(posedge clk) disable iff (rst)
    (job_push && accept && job.kind != KIND_DATA) |=> stopped)
    else $error("halt job without stop");
  a_data_nonempty: assert property (@(posedge clk) disable iff (rst)
    (job_push && accept && job.kind == KIND_DATA) |-> (job.dcnt != '0 || job.nb != '0))
    else $error("empty data job");
  a_tiu_range: assert property (@(posedge clk) disable iff (rst)
    tiu <= 5'(NUM_TRACKS))
    else $error("track count overflow");

endmodule

`default_nettype wire

FILE: rtl/core/mtm_back.sv
// ----------------------------------------------------------------------------
// mtm_back: result emitter
// Unpacks each job into one or more result beats: delta groups first, then
// literal bytes, or a single status beat for a halt.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtm_back (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    job_empty,
  input  mtm_pkg::job_t job,
  output logic         job_pop,
  input  wire logic    out_full,
  output logic         out_push,
  output mtm_pkg::result_t result
);
  import mtm_pkg::*;

  logic [2:0] idx;
  logic [2:0] n;
  logic [2:0] g;
  logic [2:0] bi;
  logic       is_last;

  assign n        = (job.kind != KIND_DATA) ? 3'd1 : job.dcnt + {1'b0, job.nb};
  assign is_last  = (idx == n - 3'd1);
  assign out_push = !job_empty && !out_full;
  assign job_pop  = out_push && is_last;
  assign g        = job.dcnt - 3'd1 - idx;
  assign bi       = idx - job.dcnt;

  always_comb begin
    result.track     = job.track;
    result.kind      = job.kind;
    result.last      = is_last;
    result.midi_byte = '0;
    if (job.kind == KIND_DATA) begin
      if (idx < job.dcnt) begin
        case (g)
          3'd0:    result.midi_byte = {1'b0, job.delta[6:0]};
          3'd1:    result.midi_byte = {1'b1, job.delta[13:7]};
          3'd2:    result.midi_byte = {1'b1, job.delta[20:14]};
          3'd3:    result.midi_byte = {1'b1, job.delta[27:21]};
          default: result.midi_byte = {1'b1, 3'b0, job.delta[31:28]};
        endcase
      end else begin
        result.midi_byte = (bi == 3'd0) ? job.b0 : job.b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_push) begin
      idx <= is_last ? 3'd0 : idx + 3'd1;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    !job_empty |-> (idx < n))
    else $error("beat index past job length");
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (out_push && result.last) |=> (idx == '0))
    else $error("index not reset after last beat");
  a_halt_single: assert property (@(posedge clk) disable iff (rst)
    (out_push && result.kind != KIND_DATA) |-> result.last)
    else $error("status beat not last");

endmodule

`default_nettype wire

FILE: rtl/core/mus_to_midi_event_transcoder_core.sv
// ----------------------------------------------------------------------------
// mus_to_midi_event_transcoder_core: MUS score to track-tagged MIDI bytes
// Parser front, job queue, emitter back, result queue.
// ----------------------------------------------------------------------------
// A score byte's first result beat passes through the job queue register and
//   the result queue register before it shows on the result ports.
// Throughput: one score byte per cycle into the parser while the job queue is
//   not full; the emitter puts out one result beat per cycle unless res_full.
// Reset (rst, synchronous, active high) clears the queues, the song state and
//   sets melodic_channels to 0 and running_status_enable to 1; no clear pass.
`timescale 1ns / 1ps
`default_nettype none

module mus_to_midi_event_transcoder_core #(
  parameter int JOB_DEPTH = mtm_pkg::JOB_DEPTH,
  parameter int OUT_DEPTH = mtm_pkg::OUT_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // score byte input, queue style
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] score_byte,
  input  wire logic       new_song,
  // configuration writes
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_data,
  // result beats, queue style
  output logic            empty,
  input  wire logic       pop,
  output logic [3:0]      track,
  output logic [7:0]      midi_byte,
  output logic [1:0]      kind,
  output logic            last
);
  import mtm_pkg::*;

  job_t    job_wr, job_rd;
  logic    job_push, job_full, job_empty, job_pop;
  result_t res_wr, res_rd;
  logic    res_push, res_full;

  // front: parses each beat and hands at most one job per byte
  mtm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .score_byte (score_byte),
    .new_song   (new_song),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .job_push   (job_push),
    .job        (job_wr),
    .job_full   (job_full)
  );

  // decoupling queue: front keeps parsing while the back drains long events
  mtm_fifo #(.item_t(job_t), .DEPTH(JOB_DEPTH)) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_wr),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_rd),
    .empty   (job_empty)
  );

  // back: one result beat per cycle from the head job while the result queue is not full
  mtm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_rd),
    .job_pop   (job_pop),
    .out_full  (res_full),
    .out_push  (res_push),
    .result    (res_wr)
  );

  // output queue parts the emitter from a stalled consumer
  mtm_fifo #(.item_t(result_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign track     = res_rd.track;
  assign midi_byte = res_rd.midi_byte;
  assign kind      = res_rd.kind;
  assign last      = res_rd.last;

endmodule

`default_nettype wire

FILE: tb/mtm_score_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_score_checker: transcoding predictor and result scoreboard
// Watches score beats, config writes and result beats; predicts the MIDI
// bytes each score byte causes and compares them in order.
// ----------------------------------------------------------------------------
module mtm_score_checker
  import mtm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       full,
  input  wire logic [7:0] score_byte,
  input  wire logic       new_song,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_data,
  input  wire logic       empty,
  input  wire logic       pop,
  input  wire logic [3:0] track,
  input  wire logic [7:0] midi_byte,
  input  wire logic [1:0] kind,
  input  wire logic       last,
  output int              errors,
  output int              outstanding,
  output int              beats_seen
);

  logic [3:0]  mel_count;
  logic        rs_en;
  phase_t      phase;
  logic [7:0]  cur_ev;
  logic [3:0]  cur_trk;
  logic [4:0]  chan_map [16];
  logic [3:0]  trk_of   [16];
  logic [4:0]  n_tracks;
  logic [7:0]  run_st   [16];
  logic [7:0]  velocity [16];
  logic [31:0] delta_acc[16];
  logic [31:0] gather;
  logic        halted;

  result_t midi_q[$];
  result_t step_q[$];

  localparam logic [7:0] CTL_LUT [15] = '{8'h00, 8'h00, 8'h01, 8'h07, 8'h0A, 8'h0B,
    8'h5B, 8'h5D, 8'h40, 8'h43, 8'h78, 8'h7B, 8'h7E, 8'h7F, 8'h79};

  task automatic clear_song();
    phase = PH_EVENT; cur_ev = '0; cur_trk = '0; n_tracks = '0; gather = '0;
    halted = 1'b0;
    for (int i = 0; i < 16; i++) begin
      chan_map[i] = UNMAPPED; trk_of[i] = '0;
      run_st[i] = '0; velocity[i] = DEF_VEL; delta_acc[i] = '0;
    end
  endtask

  task automatic put_byte(input logic [3:0] t, input logic [7:0] b, input kind_t k);
    result_t r;
    r.track = t; r.midi_byte = b; r.kind = k; r.last = 1'b0;
    if (step_q.size() < 6) step_q.push_back(r);
  endtask

  task automatic stop_song(input kind_t k);
    put_byte('0, '0, k);
    halted = 1'b1;
  endtask

  task automatic put_status(input logic [3:0] t, input logic [7:0] s);
    if (!rs_en || run_st[t] != s) begin
      put_byte(t, s, KIND_DATA);
      run_st[t] = s;
    end
  endtask

  task automatic put_delta(input logic [3:0] t, input logic [31:0] v);
    int groups;
    logic [6:0] g;
    groups = 1;
    for (int i = 1; i < 5; i++) if ((v >> (7 * i)) != 0) groups = i + 1;
    for (int i = groups - 1; i >= 0; i--) begin
      g = 7'(v >> (7 * i));
      put_byte(t, (i != 0) ? {1'b1, g} : {1'b0, g}, KIND_DATA);
    end
  endtask

  task automatic finish_event();
    if (cur_ev[7]) begin
      gather = '0; phase = PH_TIME;
    end else phase = PH_EVENT;
  endtask

  task automatic take_event(input logic [7:0] b);
    logic [2:0] et;
    logic [3:0] ch, mc, t;
    int top;
    int c;
    et = b[6:4]; ch = b[3:0];
    if (et == ET_END) begin
      stop_song(KIND_END);
      return;
    end
    if (chan_map[ch] == UNMAPPED) begin
      if (ch == PERC_MUS) c = PERC_MIDI;
      else begin
        top = -1;
        for (int i = 0; i < 15; i++)
          if (chan_map[i] != UNMAPPED && int'(chan_map[i]) > top) top = chan_map[i];
        c = (top == 8) ? 10 : top + 1;
      end
      if (c > 15 || n_tracks >= NUM_TRACKS) begin
        stop_song(KIND_CHANNELS);
        return;
      end
      chan_map[ch] = c[4:0];
      trk_of[c] = n_tracks[3:0];
      n_tracks++;
    end
    mc = chan_map[ch][3:0];
    t = trk_of[mc];
    cur_trk = t; cur_ev = b;
    if (et == ET_BAD5 || et == ET_BAD7) begin
      stop_song(KIND_CORRUPT);
      return;
    end
    put_delta(t, delta_acc[t]);
    delta_acc[t] = '0;
    case (et)
      ET_OFF:  begin put_status(t, ST_NOTE | mc); phase = PH_OFF; end
      ET_ON:   begin put_status(t, ST_NOTE | mc); phase = PH_ON; end
      ET_BEND: begin put_status(t, ST_BEND | mc); phase = PH_BEND; end
      ET_CTRL: begin put_status(t, ST_CTRL | mc); phase = PH_CTRL; end
      default: phase = PH_CHGSEL;
    endcase
  endtask

  task automatic transcode(input logic [7:0] b, input logic ns);
    logic [3:0] t, mc;
    step_q.delete();
    if (ns) clear_song();
    if (halted) return;
    t = cur_trk;
    mc = chan_map[cur_ev[3:0]][3:0];
    case (phase)
      PH_EVENT: take_event(b);
      PH_OFF: begin
        put_byte(t, b, KIND_DATA); put_byte(t, 8'h00, KIND_DATA); finish_event();
      end
      PH_ON: begin
        put_byte(t, {1'b0, b[6:0]}, KIND_DATA);
        if (b[7]) phase = PH_VALUE;
        else begin
          put_byte(t, velocity[t], KIND_DATA); finish_event();
        end
      end
      PH_BEND: begin
        put_byte(t, {1'b0, b[0], 6'b0}, KIND_DATA); put_byte(t, b >> 1, KIND_DATA);
        finish_event();
      end
      PH_CTRL: begin
        if (b > CTL_MAX) stop_song(KIND_CORRUPT);
        else begin
          put_byte(t, CTL_LUT[b], KIND_DATA);
          put_byte(t, (b == CTL_MONO) ? {4'b0, mel_count} + 8'd1 : 8'd0, KIND_DATA);
          finish_event();
        end
      end
      PH_CHGSEL: begin
        if (b > CTL_MAX) stop_song(KIND_CORRUPT);
        else begin
          if (b != 0) begin
            put_status(t, ST_CTRL | mc); put_byte(t, CTL_LUT[b], KIND_DATA);
          end else put_status(t, ST_PROG | mc);
          phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (cur_ev[6:4] == ET_ON) velocity[t] = b;
        put_byte(t, b, KIND_DATA); finish_event();
      end
      default: begin
        gather = (gather << 7) + {25'b0, b[6:0]};
        if (!b[7]) begin
          for (int i = 0; i < n_tracks && i < NUM_TRACKS; i++)
            delta_acc[i] += gather;
          phase = PH_EVENT;
        end
      end
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) midi_q.push_back(step_q[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mel_count <= '0;
      rs_en <= 1'b1;
      clear_song();
      midi_q.delete();
      errors <= 0;
      beats_seen <= 0;
    end else begin
      if (pop && !empty) begin
        beats_seen <= beats_seen + 1;
        if (midi_q.size() == 0) begin
          $display("%0t: expected no beat, got trk=%0d byte=%02h kind=%0d last=%0b",
                   $time, track, midi_byte, kind, last);
          errors <= errors + 1;
        end else begin
          if (midi_q[0].track != track || midi_q[0].midi_byte != midi_byte ||
              midi_q[0].kind != kind_t'(kind) || midi_q[0].last != last) begin
            $display("%0t: expected trk=%0d byte=%02h kind=%0d last=%0b, got trk=%0d byte=%02h kind=%0d last=%0b",
                     $time, midi_q[0].track, midi_q[0].midi_byte, midi_q[0].kind,
                     midi_q[0].last, track, midi_byte, kind, last);
            errors <= errors + 1;
          end
          void'(midi_q.pop_front());
        end
      end
      if (push && !full) transcode(score_byte, new_song);
      if (cfg_we) begin
        if (cfg_index == REG_MELODIC) mel_count <= cfg_data;
        else rs_en <= cfg_data[0];
      end
    end
  end

  assign outstanding = midi_q.size();

endmodule

FILE: tb/tb_mus_to_midi_event_transcoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mus_to_midi_event_transcoder_core: score stream test for the transcoder
// Feeds well-formed MUS event sequences with random content, some corrupt
// ones and raw noise, across several config settings and idle patterns; the
// checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_mus_to_midi_event_transcoder_core;
  import mtm_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] score_byte;
  logic       new_song;
  logic       cfg_we;
  logic       cfg_index;
  logic [3:0] cfg_data;
  logic       empty;
  logic       pop;
  logic [3:0] track;
  logic [7:0] midi_byte;
  logic [1:0] kind;
  logic       last;

  int errors, outstanding, beats_seen;
  int idle_pct, stall_pct;
  int events_sent, bytes_sent, idle_cycles;
  logic song_open;  // next byte may continue the current song

  mus_to_midi_event_transcoder_core u_dut (
    .clk, .rst, .push, .full, .score_byte, .new_song,
    .cfg_we, .cfg_index, .cfg_data,
    .empty, .pop, .track, .midi_byte, .kind, .last
  );

  mtm_score_checker u_chk (
    .clk, .rst, .push, .full, .score_byte, .new_song,
    .cfg_we, .cfg_index, .cfg_data,
    .empty, .pop, .track, .midi_byte, .kind, .last,
    .errors, .outstanding, .beats_seen
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls at the configured rate
  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  // one score beat; push left high so back-to-back beats need no gap
  task automatic send(input logic [7:0] b, input logic ns = 1'b0);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    score_byte <= b;
    new_song <= ns;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic release_push();
    @(negedge clk);
    push <= 1'b0;
  endtask

  // idle the input until all results are back, then let the pipe empty
  task automatic drain();
    release_push();
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [3:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // time field after a "last" event: 1..3 groups, sometimes a 5-group monster
  task automatic send_time();
    int groups;
    groups = ($urandom_range(9) == 0) ? 5 : $urandom_range(1, 3);
    for (int i = groups - 1; i >= 0; i--)
      send({(i != 0), 7'($urandom)});
  endtask

  // one MUS event, mostly well formed; closes the song when it would halt it
  task automatic send_event(input logic [2:0] et, input logic [3:0] ch, input logic lst);
    logic [7:0] v;
    logic bad;
    bad = ($urandom_range(19) == 0);
    send({lst, et, ch}, !song_open);
    song_open = 1'b1;
    events_sent++;
    case (et)
      ET_OFF, ET_BEND: send(8'($urandom));
      ET_ON: begin
        v = 8'($urandom);
        send(v);
        if (v[7]) send(8'($urandom));
      end
      ET_CTRL: begin
        send(bad ? 8'($urandom_range(15, 255)) : 8'($urandom_range(0, 14)));
        if (bad) song_open = 1'b0;
      end
      ET_CHG: begin
        send(bad ? 8'($urandom_range(15, 255)) : 8'($urandom_range(0, 14)));
        if (bad) song_open = 1'b0;
        else send(8'($urandom));
      end
      default: song_open = 1'b0;  // end of score or corrupt type
    endcase
    if (song_open && lst) send_time();
  endtask

  task automatic random_traffic(input int n);
    logic [2:0] et;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) begin
        // noise, with a random new-song flag
        send(8'($urandom), 1'($urandom));
        song_open = 1'b0;
      end else begin
        et = ($urandom_range(24) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        send_event(et, 4'($urandom), 1'($urandom));
      end
      if (i == n / 2) drain();  // pressure point: wait for every result
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0; score_byte = '0; new_song = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_MELODIC; cfg_data = '0;
    idle_pct = 0; stall_pct = 0;
    events_sent = 0; bytes_sent = 0; idle_cycles = 0;
    song_open = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: each valid event type, end of score, a corrupt type, field extremes, mono value, long delta
    send_event(ET_OFF, 4'd0, 1'b0);
    send_event(ET_ON, 4'd15, 1'b0);
    send_event(ET_BEND, 4'd1, 1'b1);
    send_event(ET_CTRL, 4'd2, 1'b0);
    send({1'b0, ET_CTRL, 4'd2}); send(CTL_MONO);
    send({1'b1, ET_CHG, 4'd2}); send(8'd0); send(8'hFF);
    send(8'hFF); send(8'hFF); send(8'hFF); send(8'hFF); send(8'h7F);
    send({1'b0, ET_ON, 4'd2}); send(8'hFF); send(8'h00);
    send({1'b0, ET_CHG, 4'd2}); send(8'd14); send(8'h7F);
    send({1'b0, ET_CTRL, 4'd3}); send(8'hFF);        // bad controller index
    send(8'h00);                                     // ignored while halted
    send({1'b0, ET_END, 4'd0}, 1'b1);
    send({1'b0, ET_BAD7, 4'd9}, 1'b1);
    song_open = 1'b0;
    drain();

    // phases: four config settings, each with its own idle pattern
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0; end
        1: begin idle_pct = 87; stall_pct = 0; end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      write_cfg(REG_MELODIC, (p[0]) ? 4'd15 : 4'($urandom_range(0, 14)));
      write_cfg(REG_RUNSTAT, (p == 1) ? 1'b0 : p[1]);
      song_open = 1'b0;
      random_traffic(10);
      drain();
    end

    $display("Sent %0d score bytes (%0d events) and checked %0d result beats,",
             bytes_sent, events_sent, beats_seen);
    $display("over four config and idle settings with running status on and off.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: mus_to_midi_event_transcoder_core.f
rtl/core/mtm_pkg.sv
rtl/core/mtm_fifo.sv
rtl/core/mtm_front.sv
rtl/core/mtm_back.sv
rtl/core/mus_to_midi_event_transcoder_core.sv
tb/mtm_score_checker.sv
tb/tb_mus_to_midi_event_transcoder_core.sv
